FILE: hdl/assert_macros.svh
// Assertion macros for the list block checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define OVL_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, masked while reset is asserted.
`define OVL_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/ovl_pkg.sv
package ovl_pkg;

    // List depth and derived widths
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FIELD_W  = 5;
    localparam int VALUE_W  = 32;

    // Command codes
    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_DUMP   = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    // Command beat
    typedef struct packed {
        action_t                    action;
        logic signed [VALUE_W-1:0]  value;
    } cmd_beat_t;

    // Response beat
    typedef struct packed {
        logic signed [VALUE_W-1:0]  item_value;
        logic                       item_valid;
        logic                       last_item;
        logic [FIELD_W-1:0]         entry_count;
        logic [FIELD_W-1:0]         removed_count;
        logic                       overflow;
    } rsp_beat_t;

    // Broadcast control to every cell; at most one bit set per cycle
    typedef struct packed {
        logic append;
        logic clear;
        logic mark;
        logic compact;
        logic rotate;
    } cell_ctl_t;

endpackage

FILE: hdl/ovl_cell.sv
module ovl_cell
    import ovl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cell_ctl_t           ctl,
    input  logic [VALUE_W-1:0]  key,
    input  logic                left_occ,
    input  logic [VALUE_W-1:0]  right_data,
    input  logic                right_occ,
    output logic [VALUE_W-1:0]  data,
    output logic                occ
);

    logic [VALUE_W-1:0] data_reg;
    logic [VALUE_W-1:0] data_next;
    logic               occ_reg;
    logic               occ_next;

    // Per-cell update: append fills the first free slot, mark drops matches,
    // compact pulls the right neighbor into a hole, rotate shifts toward head
    always_comb
    begin
        data_next = data_reg;
        occ_next  = occ_reg;
        if (ctl.clear)
        begin
            occ_next = 1'b0;
        end
        else if (ctl.append)
        begin
            if (!occ_reg && left_occ)
            begin
                occ_next  = 1'b1;
                data_next = key;
            end
        end
        else if (ctl.mark)
        begin
            if (occ_reg && (data_reg == key))
                occ_next = 1'b0;
        end
        else if (ctl.compact)
        begin
            if (!occ_reg)
            begin
                occ_next  = right_occ;
                data_next = right_data;
            end
            else if (!left_occ)
            begin
                // our entry moves into the hole on the left
                occ_next = 1'b0;
            end
        end
        else if (ctl.rotate)
        begin
            occ_next  = right_occ;
            data_next = right_data;
        end
    end

    // Occupancy is control state; data is payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= 1'b0;
        else
            occ_reg <= occ_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign occ  = occ_reg;

endmodule

FILE: hdl/ordered_value_list.sv
// Ordered list of up to CAPACITY signed 32-bit values, kept in a row of cells
// with the head in cell 0. Append writes the first free cell and answers
// through ST_RESP, as do clear and a dump of an empty list. Delete clears every
// matching cell in the accept cycle, then the holes bubble toward the tail one
// cell per cycle until the row is packed; once ST_COMPACT sees the packed row,
// the single response follows through ST_RESP. Dump rotates the whole ring
// once, sending cell 0 as a beat while it holds a stored entry; the ring and
// the dump pause while a beat is due and the response side stalls. One command
// is worked at a time; a command is taken while the last response beat still
// waits in the output register.
module ordered_value_list
    import ovl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  cmd_beat_t  cmd,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output rsp_beat_t  rsp
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPACT,
        ST_DUMP,
        ST_RESP
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   removed_reg;
    logic [CNT_W-1:0]   removed_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic [IDX_W-1:0]   step_reg;
    logic [IDX_W-1:0]   step_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    rsp_beat_t          rsp_reg;
    rsp_beat_t          rsp_next;

    cell_ctl_t          ctl;
    logic [VALUE_W-1:0] cell_data  [CAPACITY];
    logic [CAPACITY-1:0] cell_occ;
    logic [VALUE_W-1:0] right_data [CAPACITY];
    logic [CAPACITY-1:0] right_occ;
    logic [CAPACITY-1:0] left_occ;

    logic               accept;
    logic               out_free;
    logic               gap;
    logic [CNT_W-1:0]   packed_count;
    logic [CNT_W-1:0]   step_ext;
    logic               dump_emit;

    assign accept   = cmd_valid && !cmd_stall;
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign step_ext = CNT_W'(step_reg);
    assign dump_emit = step_ext < count_reg;

    // Neighbor wiring; the tail's right input closes the ring only on rotate
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (i == 0)
                left_occ[i] = 1'b1;
            else
                left_occ[i] = cell_occ[i-1];
            if (i == CAPACITY - 1)
            begin
                right_data[i] = cell_data[0];
                right_occ[i]  = ctl.rotate && cell_occ[0];
            end
            else
            begin
                right_data[i] = cell_data[i+1];
                right_occ[i]  = cell_occ[i+1];
            end
        end
    end

    // Cell row
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        ovl_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .key        (cmd.value),
            .left_occ   (left_occ[g]),
            .right_data (right_data[g]),
            .right_occ  (right_occ[g]),
            .data       (cell_data[g]),
            .occ        (cell_occ[g])
        );
    end

    // Hole detection and packed length from the tail marker
    always_comb
    begin
        gap          = 1'b0;
        packed_count = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (i < CAPACITY - 1)
            begin
                if (!cell_occ[i] && cell_occ[i+1])
                    gap = 1'b1;
                if (cell_occ[i] && !cell_occ[i+1])
                    packed_count = packed_count | CNT_W'(i + 1);
            end
            else if (cell_occ[i])
            begin
                packed_count = packed_count | CNT_W'(i + 1);
            end
        end
    end

    // Command sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        removed_next   = removed_reg;
        ovf_next       = ovf_reg;
        step_next      = step_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        ctl            = '0;
        cmd_stall      = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    removed_next = '0;
                    ovf_next     = 1'b0;
                    unique case (cmd.action)
                        ACT_APPEND:
                        begin
                            ctl.append = 1'b1;
                            if (count_reg == CNT_W'(CAPACITY))
                                ovf_next = 1'b1;
                            else
                                count_next = count_reg + CNT_W'(1);
                            state_next = ST_RESP;
                        end
                        ACT_DELETE:
                        begin
                            ctl.mark   = 1'b1;
                            state_next = ST_COMPACT;
                        end
                        ACT_DUMP:
                        begin
                            step_next = '0;
                            if (count_reg == '0)
                                state_next = ST_RESP;
                            else
                                state_next = ST_DUMP;
                        end
                        ACT_CLEAR:
                        begin
                            ctl.clear  = 1'b1;
                            count_next = '0;
                            state_next = ST_RESP;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_COMPACT:
            begin
                ctl.compact = 1'b1;
                if (!gap)
                begin
                    count_next   = packed_count;
                    removed_next = count_reg - packed_count;
                    state_next   = ST_RESP;
                end
            end
            ST_DUMP:
            begin
                if (out_free || !dump_emit)
                begin
                    ctl.rotate = 1'b1;
                    if (dump_emit)
                    begin
                        rsp_valid_next         = 1'b1;
                        rsp_next.item_value    = cell_data[0];
                        rsp_next.item_valid    = 1'b1;
                        rsp_next.last_item     = (step_ext + CNT_W'(1)) == count_reg;
                        rsp_next.entry_count   = FIELD_W'(count_reg);
                        rsp_next.removed_count = '0;
                        rsp_next.overflow      = 1'b0;
                    end
                    step_next = step_reg + IDX_W'(1);
                    if (step_reg == IDX_W'(CAPACITY - 1))
                        state_next = ST_IDLE;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.item_value    = '0;
                    rsp_next.item_valid    = 1'b0;
                    rsp_next.last_item     = 1'b1;
                    rsp_next.entry_count   = FIELD_W'(count_reg);
                    rsp_next.removed_count = FIELD_W'(removed_reg);
                    rsp_next.overflow      = ovf_reg;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            removed_reg   <= '0;
            ovf_reg       <= 1'b0;
            step_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            removed_reg   <= removed_next;
            ovf_reg       <= ovf_next;
            step_reg      <= step_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: hdl/ovl_checker.sv
`include "assert_macros.svh"

module ovl_checker
    import ovl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  logic       cmd_stall,
    input  cmd_beat_t  cmd,
    input  logic       rsp_valid,
    input  logic       rsp_stall,
    input  rsp_beat_t  rsp
);

    // one command at a time: a taken beat blocks the next cycle
    `OVL_ASSERT_NXT(a_cmd_busy, clk, rst_n, cmd_valid && !cmd_stall, cmd_stall)

    // only dump beats carry entries; every other response is a single last beat
    `OVL_ASSERT_IMP(a_single_last, clk, rst_n, rsp_valid && !rsp.item_valid, rsp.last_item)

    `OVL_ASSERT_IMP(a_value_zero, clk, rst_n, rsp_valid && !rsp.item_valid,
                    rsp.item_value == '0)

    // overflow belongs to an append response
    `OVL_ASSERT_IMP(a_ovf_alone, clk, rst_n, rsp_valid && rsp.overflow,
                    !rsp.item_valid && (rsp.removed_count == '0))

    // stalled response beat holds
    `OVL_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall,
                    rsp_valid && $stable(rsp))

endmodule

bind ordered_value_list ovl_checker u_ovl_checker (.*);

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import ovl_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 4 * CAPACITY + 16;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    // receiver stall patterns
    typedef enum int {
        RX_FREE,
        RX_RANDOM,
        RX_TOGGLE,
        RX_HOLD
    } rx_mode_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_beat_t cmd = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_beat_t rsp;

    // list state as the block should hold it
    logic signed [VALUE_W-1:0] list_vals [CAPACITY];
    int                        list_len = 0;

    // response beats still owed by the block, oldest first
    rsp_beat_t due_rsp [$];

    int       errors = 0;
    int       quiet_cycles = 0;
    int       burst_left = 0;
    bit       gaps_on = 1'b1;
    rx_mode_t rx_mode = RX_FREE;
    int       rx_left = 0;

    ordered_value_list dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Work out the response beats of one command and update the list
    function automatic void predict_response(cmd_beat_t c);
        rsp_beat_t r;
        int        keep;
        r = '0;
        r.last_item = 1'b1;
        case (c.action)
            ACT_APPEND:
            begin
                if (list_len < CAPACITY)
                begin
                    list_vals[list_len] = c.value;
                    list_len++;
                end
                else
                    r.overflow = 1'b1;
                r.entry_count = FIELD_W'(list_len);
                due_rsp.push_back(r);
            end
            ACT_DELETE:
            begin
                // drop every match, survivors close up in order
                keep = 0;
                for (int i = 0; i < list_len; i++)
                begin
                    if (list_vals[i] != c.value)
                    begin
                        list_vals[keep] = list_vals[i];
                        keep++;
                    end
                end
                r.removed_count = FIELD_W'(list_len - keep);
                list_len = keep;
                r.entry_count = FIELD_W'(list_len);
                due_rsp.push_back(r);
            end
            ACT_DUMP:
            begin
                if (list_len == 0)
                    due_rsp.push_back(r);
                for (int i = 0; i < list_len; i++)
                begin
                    r.item_value  = list_vals[i];
                    r.item_valid  = 1'b1;
                    r.last_item   = (i == list_len - 1);
                    r.entry_count = FIELD_W'(list_len);
                    due_rsp.push_back(r);
                end
            end
            default:
            begin
                list_len = 0;
                due_rsp.push_back(r);
            end
        endcase
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Send one command beat; hold it until taken, then maybe pause between bursts
    task automatic send_cmd(action_t act, logic signed [VALUE_W-1:0] val);
        cmd_beat_t c;
        c.action = act;
        c.value  = val;
        cmd       <= c;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        predict_response(c);
        if (gaps_on && burst_left == 0)
        begin
            cmd_valid <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(9, 20)) @(posedge clk);
            else
                repeat ($urandom_range(1, 4)) @(posedge clk);
            burst_left = $urandom_range(0, 12);
        end
        else if (burst_left > 0)
            burst_left--;
    endtask

    // Commands on an empty list
    task automatic test_empty_list();
        send_cmd(ACT_DUMP, 32'sd0);
        send_cmd(ACT_DELETE, VAL_MIN);
        send_cmd(ACT_CLEAR, VAL_MAX);
    endtask

    // Extreme values, head/tail/back-to-back deletes, append after clear
    task automatic test_append_delete_order();
        send_cmd(ACT_APPEND, VAL_MAX);
        send_cmd(ACT_APPEND, VAL_MAX);
        send_cmd(ACT_APPEND, VAL_MIN);
        send_cmd(ACT_APPEND, 32'sd0);
        send_cmd(ACT_APPEND, -32'sd1);
        send_cmd(ACT_APPEND, VAL_MAX);
        send_cmd(ACT_DUMP, 32'sd0);
        send_cmd(ACT_DELETE, VAL_MAX);
        send_cmd(ACT_DUMP, VAL_MAX);
        send_cmd(ACT_DELETE, 32'sd5);
        send_cmd(ACT_DELETE, -32'sd1);
        send_cmd(ACT_DUMP, 32'sd0);
        send_cmd(ACT_CLEAR, 32'sd0);
        send_cmd(ACT_DUMP, 32'sd0);
        send_cmd(ACT_APPEND, 32'sd1);
        send_cmd(ACT_DUMP, 32'sd0);
    endtask

    // Fill past capacity from a tiny value set, then drain by value
    task automatic test_full_list(int rounds);
        logic signed [VALUE_W-1:0] fill_pool [3];
        for (int r = 0; r < rounds; r++)
        begin
            if (r == 0)
            begin
                fill_pool[0] = VAL_MIN;
                fill_pool[1] = VAL_MAX;
                fill_pool[2] = 32'sd0;
            end
            else
                foreach (fill_pool[k])
                    fill_pool[k] = $urandom;
            send_cmd(ACT_CLEAR, $urandom);
            for (int k = 0; k < CAPACITY + 2; k++)
                send_cmd(ACT_APPEND, fill_pool[$urandom_range(0, 2)]);
            send_cmd(ACT_DUMP, $urandom);
            send_cmd(ACT_DELETE, fill_pool[0]);
            send_cmd(ACT_DUMP, $urandom);
            send_cmd(ACT_DELETE, fill_pool[1]);
            send_cmd(ACT_DELETE, fill_pool[2]);
            send_cmd(ACT_DUMP, $urandom);
        end
    endtask

    // Mixed traffic; values mostly from a small pool so deletes hit
    task automatic test_random_commands(int count, bit with_gaps);
        logic signed [VALUE_W-1:0] val_pool [4];
        logic signed [VALUE_W-1:0] val;
        int                        roll;
        action_t                   act;
        gaps_on = with_gaps;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                foreach (val_pool[k])
                    val_pool[k] = $urandom;
            roll = $urandom_range(0, 99);
            if (roll < 55)
                act = ACT_APPEND;
            else if (roll < 75)
                act = ACT_DELETE;
            else if (roll < 95)
                act = ACT_DUMP;
            else
                act = ACT_CLEAR;
            roll = $urandom_range(0, 99);
            if (roll < 75)
                val = val_pool[$urandom_range(0, 3)];
            else if (roll < 85)
                case ($urandom_range(0, 3))
                    0: val = VAL_MIN;
                    1: val = VAL_MAX;
                    2: val = 32'sd0;
                    default: val = -32'sd1;
                endcase
            else
                val = $urandom;
            send_cmd(act, val);
        end
        gaps_on = 1'b1;
    endtask

    // Receiver stall pattern
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(4, 40);
            end
            rx_left--;
            case (rx_mode)
                RX_FREE:   rsp_stall <= 1'b0;
                RX_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
                RX_TOGGLE: rsp_stall <= ~rsp_stall;
                default:   rsp_stall <= (rx_left >= 4);
            endcase
        end
    end

    // Compare each accepted response beat with the oldest owed beat
    always @(posedge clk)
    begin : rsp_check
        rsp_beat_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (due_rsp.size() == 0)
            begin
                $error("unexpected response beat, item_value %0d", rsp.item_value);
                errors++;
            end
            else
            begin
                want = due_rsp.pop_front();
                check_field("item_value", want.item_value, rsp.item_value);
                check_field("item_valid", want.item_valid, rsp.item_valid);
                check_field("last_item", want.last_item, rsp.last_item);
                check_field("entry_count", want.entry_count, rsp.entry_count);
                check_field("removed_count", want.removed_count, rsp.removed_count);
                check_field("overflow", want.overflow, rsp.overflow);
            end
        end
    end

    // Watchdog: too long with no beat moving on either side
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_list();
        test_append_delete_order();
        test_full_list(4);
        test_random_commands(240, 1'b1);
        test_random_commands(40, 1'b0);
        cmd_valid <= 1'b0;
        while (due_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
